[sv/nfb_pkg.sv]
// ----------------------------------------------------------------------------
// nfb_pkg - shared types and constants of the packed 4bpp framebuffer engine
// Operation codes, store geometry, sequencer states and the store request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nfb_pkg;

  // Store geometry: two 4-bit pixels per byte.
  localparam int unsigned STORE_DEPTH = 15360;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);

  // Default screen geometry.
  localparam int unsigned SCREEN_WIDTH_DEF  = 160;
  localparam int unsigned SCREEN_HEIGHT_DEF = 192;
  localparam int unsigned ROW_BYTES_DEF     = 80;

  // Signed pixel coordinate width: holds position plus a full 8-bit span.
  localparam int unsigned CRD_W = 12;

  // Operation codes.
  localparam logic [1:0] OP_FILL  = 2'd0;
  localparam logic [1:0] OP_GLYPH = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Nibble masks.
  localparam logic [7:0] HI_MASK = 8'hf0;
  localparam logic [7:0] LO_MASK = 8'h0f;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BASE,
    ST_PIX,
    ST_MERGE,
    ST_READ,
    ST_RWAIT,
    ST_DONE
  } nfb_state_t;

  // One access to the frame store per cycle: a read, a write or both.
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
  } nfb_req_t;

endpackage

`default_nettype wire

[sv/nfb_store.sv]
// ----------------------------------------------------------------------------
// nfb_store - frame store with post-reset clearing sweep
// Single-port-write, single-port-read byte memory with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nfb_store
  import nfb_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire nfb_req_t req,
  output logic [7:0]    rd_data,
  output logic          busy
);

  logic [7:0]        mem [STORE_DEPTH];
  logic [7:0]        rd_data_r;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  logic              busy_r, busy_nxt;

  // Sweep zeros through every byte after reset.
  always_comb begin
    clr_addr_nxt = clr_addr_r;
    busy_nxt     = busy_r;
    if (busy_r) begin
      clr_addr_nxt = clr_addr_r + ADDR_W'(1);
      if (clr_addr_r == ADDR_W'(STORE_DEPTH - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      busy_r     <= 1'b1;
    end else begin
      clr_addr_r <= clr_addr_nxt;
      busy_r     <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[clr_addr_r] <= 8'h00;
    end else if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;
  assign busy    = busy_r;

endmodule

`default_nettype wire

[sv/nibble_framebuffer_glyph_and_fill.sv]
// ----------------------------------------------------------------------------
// nibble_framebuffer_glyph_and_fill - packed 4bpp framebuffer drawing engine
// Fills rectangles, draws 8-pixel glyph rows and reads back stored bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one request: fill, glyph row or
//   byte read. Output channel (out_valid/out_ready) returns exactly one
//   out_read_data per request: the stored byte for an in-range read, zero otherwise.
//   The engine works on one request at a time; in_ready is high only while
//   idle. Every pixel of the request span is visited in turn by one shared
//   address adder and a single memory port: a drawn pixel is a read-modify-
//   write of its nibble, while a clipped or blank pixel is only stepped over.
//   A read issues the store read and then takes the registered byte; every
//   request ends by handing its result to the output register.
//   The output register decouples the sides: a new request is taken while
//   a result still waits, and the engine holds in its done state until the
//   receiver frees the output register.
//   After reset the store is swept to zero one byte per cycle; in_ready
//   stays low during the sweep.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nibble_framebuffer_glyph_and_fill
  import nfb_pkg::*;
#(
  parameter int unsigned SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
  parameter int unsigned ROW_BYTES     = ROW_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_operation,
  input  wire logic [9:0]  in_x_pos,
  input  wire logic [9:0]  in_y_pos,
  input  wire logic [7:0]  in_rect_width,
  input  wire logic [7:0]  in_rect_height,
  input  wire logic [3:0]  in_color,
  input  wire logic [7:0]  in_row_bits,
  input  wire logic [13:0] in_read_address,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_read_data
);

  // Row base needs room for (y * ROW_BYTES) over the full signed y range.
  localparam int unsigned RB_W   = $clog2(ROW_BYTES + 1);
  localparam int unsigned BASE_W = CRD_W + RB_W + 4;

  localparam logic signed [CRD_W-1:0]  SW_S    = CRD_W'(SCREEN_WIDTH);
  localparam logic signed [CRD_W-1:0]  SH_S    = CRD_W'(SCREEN_HEIGHT);
  localparam logic signed [BASE_W-1:0] RB_S    = BASE_W'(ROW_BYTES);
  localparam logic signed [BASE_W-1:0] DEPTH_S = BASE_W'(STORE_DEPTH);

  nfb_state_t               state_r, state_nxt;
  logic [1:0]               op_r, op_nxt;
  logic signed [CRD_W-1:0]  x_pos_r, x_pos_nxt;
  logic signed [CRD_W-1:0]  x_cur_r, x_cur_nxt;
  logic signed [CRD_W-1:0]  y_cur_r, y_cur_nxt;
  logic signed [BASE_W-1:0] row_base_r, row_base_nxt;
  logic [7:0]               col_r, col_nxt;
  logic [7:0]               row_r, row_nxt;
  logic [7:0]               span_r, span_nxt;
  logic [7:0]               height_r, height_nxt;
  logic [7:0]               bits_r, bits_nxt;
  logic [3:0]               color_r, color_nxt;
  logic [13:0]              raddr_r, raddr_nxt;
  logic [ADDR_W-1:0]        wr_addr_r, wr_addr_nxt;
  logic                     odd_r, odd_nxt;
  logic [7:0]               data_r, data_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [7:0]               out_data_r, out_data_nxt;

  nfb_req_t                 store_req;
  logic [7:0]               store_rd_data;
  logic                     store_busy;

  logic signed [BASE_W-1:0] y_ext;
  logic signed [BASE_W-1:0] pix_addr;
  logic                     pix_on;
  logic                     advance;

  nfb_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (store_req),
    .rd_data (store_rd_data),
    .busy    (store_busy)
  );

  // Shared address unit: row base plus half the column.
  assign y_ext    = {{(BASE_W - CRD_W){y_cur_r[CRD_W-1]}}, y_cur_r};
  assign pix_addr = row_base_r
                  + {{(BASE_W - CRD_W + 1){1'b0}}, x_cur_r[CRD_W-1:1]};

  // Drawn if a fill pixel or a set glyph bit, inside screen and store.
  assign pix_on = (op_r == OP_FILL || bits_r[7])
               && !x_cur_r[CRD_W-1] && (x_cur_r < SW_S)
               && !y_cur_r[CRD_W-1] && (y_cur_r < SH_S)
               && (pix_addr < DEPTH_S);

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    x_pos_nxt    = x_pos_r;
    x_cur_nxt    = x_cur_r;
    y_cur_nxt    = y_cur_r;
    row_base_nxt = row_base_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    span_nxt     = span_r;
    height_nxt   = height_r;
    bits_nxt     = bits_r;
    color_nxt    = color_r;
    raddr_nxt    = raddr_r;
    wr_addr_nxt  = wr_addr_r;
    odd_nxt      = odd_r;
    data_nxt     = data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt = out_data_r;
    advance      = 1'b0;
    store_req    = '0;

    case (state_r)
      ST_CLEAR: begin
        if (!store_busy) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid) begin
          op_nxt     = in_operation;
          x_pos_nxt  = {{(CRD_W - 10){in_x_pos[9]}}, in_x_pos};
          x_cur_nxt  = {{(CRD_W - 10){in_x_pos[9]}}, in_x_pos};
          y_cur_nxt  = {{(CRD_W - 10){in_y_pos[9]}}, in_y_pos};
          color_nxt  = in_color;
          bits_nxt   = in_row_bits;
          raddr_nxt  = in_read_address;
          col_nxt    = '0;
          row_nxt    = '0;
          data_nxt   = '0;
          span_nxt   = (in_operation == OP_FILL) ? in_rect_width : 8'd8;
          height_nxt = (in_operation == OP_FILL) ? in_rect_height : 8'd1;
          case (in_operation)
            OP_FILL, OP_GLYPH: state_nxt = ST_BASE;
            OP_READ:           state_nxt = ST_READ;
            default:           state_nxt = ST_DONE;
          endcase
        end
      end

      ST_BASE: begin
        // One multiply per request; rows after the first add ROW_BYTES.
        row_base_nxt = BASE_W'(y_ext * RB_S);
        if (span_r == 8'd0 || height_r == 8'd0) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_PIX;
        end
      end

      ST_PIX: begin
        if (pix_on) begin
          store_req.rd_en   = 1'b1;
          store_req.rd_addr = pix_addr[ADDR_W-1:0];
          wr_addr_nxt       = pix_addr[ADDR_W-1:0];
          odd_nxt           = x_cur_r[0];
          state_nxt         = ST_MERGE;
        end else begin
          advance = 1'b1;
        end
      end

      ST_MERGE: begin
        // Replace one nibble of the byte just read, keep the other.
        store_req.wr_en   = 1'b1;
        store_req.wr_addr = wr_addr_r;
        store_req.wr_data = odd_r ? ((store_rd_data & HI_MASK) | {4'h0, color_r})
                                  : ((store_rd_data & LO_MASK) | {color_r, 4'h0});
        advance = 1'b1;
      end

      ST_READ: begin
        store_req.rd_en   = 1'b1;
        store_req.rd_addr = raddr_r[ADDR_W-1:0];
        state_nxt         = ST_RWAIT;
      end

      ST_RWAIT: begin
        data_nxt  = (raddr_r < 14'(STORE_DEPTH)) ? store_rd_data : 8'h00;
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        // Hold until the output register is free.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = data_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_CLEAR;
    endcase

    // Step to the next pixel of the span, row by row.
    if (advance) begin
      state_nxt = ST_PIX;
      bits_nxt  = {bits_r[6:0], 1'b0};
      if (col_r == 8'(span_r - 8'd1)) begin
        col_nxt   = '0;
        x_cur_nxt = x_pos_r;
        if (row_r == 8'(height_r - 8'd1)) begin
          state_nxt = ST_DONE;
        end else begin
          row_nxt      = row_r + 8'd1;
          y_cur_nxt    = y_cur_r + CRD_W'(1);
          row_base_nxt = row_base_r + RB_S;
        end
      end else begin
        col_nxt   = col_r + 8'd1;
        x_cur_nxt = x_cur_r + CRD_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    x_pos_r    <= x_pos_nxt;
    x_cur_r    <= x_cur_nxt;
    y_cur_r    <= y_cur_nxt;
    row_base_r <= row_base_nxt;
    col_r      <= col_nxt;
    row_r      <= row_nxt;
    span_r     <= span_nxt;
    height_r   <= height_nxt;
    bits_r     <= bits_nxt;
    color_r    <= color_nxt;
    raddr_r    <= raddr_nxt;
    wr_addr_r  <= wr_addr_nxt;
    odd_r      <= odd_nxt;
    data_r     <= data_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready      = (state_r == ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;

`ifndef NO_ASSERTIONS
  // No request is taken while the clearing sweep runs.
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    store_busy |-> !in_ready)
    else $error("request accepted during store clear");

  // Every pixel write lands on the byte read in the cycle before.
  a_rmw_same_addr: assert property (@(posedge clk) disable iff (!rst_n)
    store_req.wr_en |-> ($past(store_req.rd_en)
                         && store_req.wr_addr == $past(store_req.rd_addr)))
    else $error("write address differs from preceding read");

  // Drawing and unused operations return zero.
  a_draw_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && op_r != OP_READ) |-> (data_r == 8'h00))
    else $error("nonzero result for a drawing request");

  // A result is loaded only into a free output register.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_data_r)))
    else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire
